/* rtl/greedy_lightest_edge_walk_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the greedy lightest-edge walk core
// Immediate-style concurrent checks that compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef GREEDY_LIGHTEST_EDGE_WALK_CORE_ASSERT_SVH
`define GREEDY_LIGHTEST_EDGE_WALK_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GLW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("glw assertion failed");
// next-cycle implication
`define GLW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("glw assertion failed");
`else
`define GLW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GLW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/glw_pkg.sv */
// ----------------------------------------------------------------------------
// glw_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package glw_pkg;

	localparam int NODE_BITS      = 3;
	localparam int STEP_BITS      = 8;
	localparam int LIMIT_BITS     = 4;
	localparam int WEIGHT_IN_BITS = 16;
	localparam int OUTCOME_BITS   = 2;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd7;
	localparam logic [STEP_BITS-1:0]  STEP_MAX    = 8'hFF;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [OUTCOME_BITS-1:0] OUT_WRITE = 2'd0;
	localparam logic [OUTCOME_BITS-1:0] OUT_FOUND = 2'd1;
	localparam logic [OUTCOME_BITS-1:0] OUT_LIMIT = 2'd2;
	localparam logic [OUTCOME_BITS-1:0] OUT_DEAD  = 2'd3;

	typedef struct packed {
		logic                    accept;
		logic                    clear_scan;
		logic                    issue;
		logic                    take_hop;
		logic                    finish;
		logic [OUTCOME_BITS-1:0] code;
		logic                    load_out;
	} glw_cmd_t;

	typedef struct packed {
		logic is_query;
		logic over_limit;
		logic bad_node;
		logic scan_more;
		logic found_edge;
		logic at_dest;
	} glw_stat_t;

endpackage

/* rtl/glw_if.sv */
// ----------------------------------------------------------------------------
// glw stream interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface glw_req_if import glw_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [NODE_BITS-1:0]      edge_from;
	logic [NODE_BITS-1:0]      edge_to;
	logic [WEIGHT_IN_BITS-1:0] edge_weight;
	logic [NODE_BITS-1:0]      start_node;
	logic [NODE_BITS-1:0]      dest_node;
	logic [STEP_BITS-1:0]      initial_steps;

	modport source (
		output valid, operation, edge_from, edge_to, edge_weight,
		       start_node, dest_node, initial_steps,
		input  ready
	);
	modport sink (
		input  valid, operation, edge_from, edge_to, edge_weight,
		       start_node, dest_node, initial_steps,
		output ready
	);
endinterface

interface glw_rsp_if import glw_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OUTCOME_BITS-1:0] outcome;
	logic [NODE_BITS-1:0]    final_node;
	logic [STEP_BITS-1:0]    hops_taken;

	modport source (
		output valid, outcome, final_node, hops_taken,
		input  ready
	);
	modport sink (
		input  valid, outcome, final_node, hops_taken,
		output ready
	);
endinterface

/* rtl/glw_ctrl.sv */
// ----------------------------------------------------------------------------
// glw_ctrl
// Walk sequencer: accept, limit check, row scan, hop, result handoff.
// ----------------------------------------------------------------------------
module glw_ctrl import glw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	input  glw_stat_t stat,
	output logic      in_ready,
	output logic      out_valid,
	output glw_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_EVAL,
		S_RESP
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = stat.is_query ? S_CHECK : S_RESP;
				end
			end
			S_CHECK: begin
				if (stat.over_limit) begin
					cmd.finish = 1'b1;
					cmd.code   = OUT_LIMIT;
					state_d    = S_RESP;
				end else if (stat.bad_node) begin
					cmd.finish = 1'b1;
					cmd.code   = OUT_DEAD;
					state_d    = S_RESP;
				end else begin
					cmd.clear_scan = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				// last read word is compared during the cycle that leaves SCAN
				if (stat.scan_more) begin
					cmd.issue = 1'b1;
				end else begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (!stat.found_edge) begin
					cmd.finish = 1'b1;
					cmd.code   = OUT_DEAD;
					state_d    = S_RESP;
				end else begin
					cmd.take_hop = 1'b1;
					if (stat.at_dest) begin
						cmd.finish = 1'b1;
						cmd.code   = OUT_FOUND;
						state_d    = S_RESP;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/glw_dp.sv */
// ----------------------------------------------------------------------------
// glw_dp
// Weight memory, row scan compare, walk registers and result register.
// ----------------------------------------------------------------------------
module glw_dp import glw_pkg::*; #(
	parameter int MAX_NODES   = 8,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  glw_cmd_t                  cmd,
	output glw_stat_t                 stat,
	input  logic                      cfg_we,
	input  logic [LIMIT_BITS-1:0]     cfg_wdata,
	input  logic                      operation,
	input  logic [NODE_BITS-1:0]      edge_from,
	input  logic [NODE_BITS-1:0]      edge_to,
	input  logic [WEIGHT_IN_BITS-1:0] edge_weight,
	input  logic [NODE_BITS-1:0]      start_node,
	input  logic [NODE_BITS-1:0]      dest_node,
	input  logic [STEP_BITS-1:0]      initial_steps,
	output logic [OUTCOME_BITS-1:0]   outcome,
	output logic [NODE_BITS-1:0]      final_node,
	output logic [STEP_BITS-1:0]      hops_taken
);

	// node ids are 3 bits wide, so rows and columns past 7 never hold an edge
	localparam int NODES  = (MAX_NODES < (1 << NODE_BITS)) ? MAX_NODES : (1 << NODE_BITS);
	localparam int NODE_W = $clog2(NODES);
	localparam int DEPTH  = NODES * NODES;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [LIMIT_BITS-1:0] NODES_L = LIMIT_BITS'(NODES);

	logic [WEIGHT_BITS-1:0]  mem_q [DEPTH];
	logic [DEPTH-1:0]        vld_q;

	logic [LIMIT_BITS-1:0]   limit_q;
	logic [NODE_BITS-1:0]    cur_q;
	logic [NODE_BITS-1:0]    dest_q;
	logic [STEP_BITS-1:0]    step_q;
	logic [STEP_BITS-1:0]    hops_q;
	logic [OUTCOME_BITS-1:0] res_q;
	logic [LIMIT_BITS-1:0]   col_q;
	logic                    best_v_q;
	logic [WEIGHT_BITS-1:0]  best_w_q;
	logic [NODE_W-1:0]       best_col_q;

	logic                    rd_act_s1;
	logic                    rd_vld_s1;
	logic [WEIGHT_BITS-1:0]  rd_w_s1;
	logic [NODE_W-1:0]       rd_col_s1;

	logic [OUTCOME_BITS-1:0] outcome_q;
	logic [NODE_BITS-1:0]    final_q;
	logic [STEP_BITS-1:0]    hops_out_q;

	logic                    wr_en;
	logic [ADDR_W-1:0]       waddr;
	logic [ADDR_W-1:0]       raddr;
	logic [LIMIT_BITS-1:0]   cols;
	logic [WEIGHT_BITS-1:0]  rd_weight;
	logic                    better;

	assign wr_en = cmd.accept && (operation == OP_WRITE)
	             && ({1'b0, edge_from} < NODES_L) && ({1'b0, edge_to} < NODES_L);
	assign waddr = ADDR_W'(int'(edge_from[NODE_W-1:0]) * NODES + int'(edge_to[NODE_W-1:0]));
	assign raddr = ADDR_W'(int'(cur_q[NODE_W-1:0]) * NODES + int'(col_q[NODE_W-1:0]));
	assign cols  = (limit_q < NODES_L) ? limit_q : NODES_L;

	// a never-written entry reads as no edge
	assign rd_weight = rd_vld_s1 ? rd_w_s1 : '0;
	assign better    = rd_act_s1 && (rd_weight != '0)
	                 && (NODE_BITS'(rd_col_s1) != cur_q)
	                 && (!best_v_q || (rd_weight < best_w_q));

	assign stat.is_query   = (operation == OP_QUERY);
	assign stat.over_limit = (step_q > STEP_BITS'(limit_q));
	assign stat.bad_node   = ({1'b0, cur_q} >= NODES_L);
	assign stat.scan_more  = (col_q < cols);
	assign stat.found_edge = best_v_q;
	assign stat.at_dest    = (NODE_BITS'(best_col_q) == dest_q);

	assign outcome    = outcome_q;
	assign final_node = final_q;
	assign hops_taken = hops_out_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= WEIGHT_BITS'(edge_weight);
		end
		if (cmd.issue) begin
			rd_w_s1   <= mem_q[raddr];
			rd_col_s1 <= col_q[NODE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			limit_q   <= LIMIT_RESET;
			col_q     <= '0;
			best_v_q  <= 1'b0;
			rd_act_s1 <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[waddr] <= 1'b1;
			end
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			rd_act_s1 <= cmd.issue;
			if (cmd.issue) begin
				rd_vld_s1 <= vld_q[raddr];
				col_q     <= col_q + LIMIT_BITS'(1);
			end
			if (cmd.clear_scan) begin
				col_q    <= '0;
				best_v_q <= 1'b0;
			end else if (better) begin
				best_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			best_w_q   <= rd_weight;
			best_col_q <= rd_col_s1;
		end
		if (cmd.accept) begin
			dest_q <= dest_node;
			step_q <= initial_steps;
			hops_q <= '0;
			if (operation == OP_QUERY) begin
				cur_q <= start_node;
			end else begin
				cur_q <= '0;
				res_q <= OUT_WRITE;
			end
		end
		if (cmd.take_hop) begin
			cur_q  <= NODE_BITS'(best_col_q);
			hops_q <= (hops_q == STEP_MAX) ? hops_q : hops_q + STEP_BITS'(1);
			step_q <= (step_q == STEP_MAX) ? step_q : step_q + STEP_BITS'(1);
		end
		if (cmd.finish) begin
			res_q <= cmd.code;
		end
		if (cmd.load_out) begin
			outcome_q  <= res_q;
			final_q    <= cur_q;
			hops_out_q <= hops_q;
		end
	end

endmodule

/* rtl/greedy_lightest_edge_walk_core.sv */
// ----------------------------------------------------------------------------
// greedy_lightest_edge_walk_core
// Weighted adjacency matrix with a greedy lightest-edge walk query.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  req      in   valid/ready      operation, edge_from/to, edge_weight,
//                                 start_node, dest_node, initial_steps
//  rsp      out  valid/ready      outcome, final_node, hops_taken
//  cfg      in   cfg_we           cfg_wdata = node_limit
//
//  Edge write: transfer, RESP state, then the result register. Query: per hop,
//  a CHECK, a row scan of C = min(node_limit, MAX_NODES, 8) columns and EVAL;
//  a step-limit stop ends in CHECK. One matrix word read per cycle during a
//  scan, on the single memory read port.
//  Reset clears per-entry valid bits at once; no clearing pass is needed.
//  One item in flight; a new item is taken while a result waits on rsp.
// ----------------------------------------------------------------------------
`include "greedy_lightest_edge_walk_core_assert.svh"

module greedy_lightest_edge_walk_core import glw_pkg::*; #(
	parameter int MAX_NODES   = 8,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [LIMIT_BITS-1:0] cfg_wdata,
	glw_req_if.sink               req,
	glw_rsp_if.source             rsp
);

	glw_cmd_t  cmd;
	glw_stat_t stat;

	glw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	glw_dp #(
		.MAX_NODES   (MAX_NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.operation     (req.operation),
		.edge_from     (req.edge_from),
		.edge_to       (req.edge_to),
		.edge_weight   (req.edge_weight),
		.start_node    (req.start_node),
		.dest_node     (req.dest_node),
		.initial_steps (req.initial_steps),
		.outcome       (rsp.outcome),
		.final_node    (rsp.final_node),
		.hops_taken    (rsp.hops_taken)
	);

	`GLW_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	`GLW_ASSERT_IMPL(a_write_result_zero, clk, arst_n, rsp.valid && (rsp.outcome == OUT_WRITE), (rsp.final_node == '0) && (rsp.hops_taken == '0))
	`GLW_ASSERT_IMPL(a_found_has_hop, clk, arst_n, rsp.valid && (rsp.outcome == OUT_FOUND), rsp.hops_taken != '0)

endmodule

/* dv/greedy_lightest_edge_walk_core_test.sv */
// ----------------------------------------------------------------------------
// Greedy lightest-edge walk core testbench
// Drives edge writes and walk queries through the request channel while the
// node_limit register is moved through several values. A scoreboard keeps its
// own copy of the weight matrix, predicts every result and checks each
// response transfer in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module greedy_lightest_edge_walk_core_test;
	import glw_pkg::*;

	localparam int NODE_COUNT       = 8;
	localparam int CLK_PERIOD       = 12;
	localparam int LIMIT_CYCLES     = 600000;
	localparam int RANDOM_PER_PHASE = 80;
	localparam int PHASE_COUNT      = 7;
	localparam int LONG_HOLD_CYCLES = 400;

	typedef struct packed {
		logic                      operation;
		logic [NODE_BITS-1:0]      edge_from;
		logic [NODE_BITS-1:0]      edge_to;
		logic [WEIGHT_IN_BITS-1:0] edge_weight;
		logic [NODE_BITS-1:0]      start_node;
		logic [NODE_BITS-1:0]      dest_node;
		logic [STEP_BITS-1:0]      initial_steps;
	} walk_req_t;

	typedef struct packed {
		logic [OUTCOME_BITS-1:0] outcome;
		logic [NODE_BITS-1:0]    final_node;
		logic [STEP_BITS-1:0]    hops_taken;
	} walk_rsp_t;

	class walk_scoreboard;
		logic [WEIGHT_IN_BITS-1:0] weight_mem [NODE_COUNT][NODE_COUNT];
		logic [LIMIT_BITS-1:0]     node_limit;
		walk_rsp_t                 expected_rsp [$];
		int                        mismatches;
		int                        results_seen;

		function new();
			foreach (weight_mem[r, c])
				weight_mem[r][c] = '0;
			node_limit   = LIMIT_RESET;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_limit(logic [LIMIT_BITS-1:0] value);
			node_limit = value;
		endfunction

		function int outstanding();
			return expected_rsp.size();
		endfunction

		function walk_rsp_t predict_walk(walk_req_t item);
			walk_rsp_t                 rsp;
			logic [NODE_BITS-1:0]      here;
			logic [STEP_BITS-1:0]      steps;
			logic [NODE_BITS-1:0]      pick;
			logic [WEIGHT_IN_BITS-1:0] pick_w;
			bit                        have_pick;
			bit                        done;
			int                        cols;
			int                        col;
			here  = item.start_node;
			steps = item.initial_steps;
			rsp   = '0;
			done  = 1'b0;
			cols  = (node_limit < NODE_COUNT) ? node_limit : NODE_COUNT;
			while (!done) begin
				if (steps > node_limit) begin
					rsp.outcome = OUT_LIMIT;
					done = 1'b1;
				end else begin
					have_pick = 1'b0;
					pick      = '0;
					pick_w    = '0;
					for (col = 0; col < cols; col++) begin
						if (weight_mem[here][col] != 0 && col != here &&
						    (!have_pick || weight_mem[here][col] < pick_w)) begin
							have_pick = 1'b1;
							pick      = NODE_BITS'(col);
							pick_w    = weight_mem[here][col];
						end
					end
					if (!have_pick) begin
						rsp.outcome = OUT_DEAD;
						done = 1'b1;
					end else begin
						here = pick;
						if (rsp.hops_taken != STEP_MAX)
							rsp.hops_taken++;
						if (pick == item.dest_node) begin
							rsp.outcome = OUT_FOUND;
							done = 1'b1;
						end else if (steps != STEP_MAX) begin
							steps++;
						end
					end
				end
			end
			rsp.final_node = here;
			return rsp;
		endfunction

		function void note_request(walk_req_t item);
			if (item.operation == OP_WRITE) begin
				weight_mem[item.edge_from][item.edge_to] = item.edge_weight;
				expected_rsp.push_back('{OUT_WRITE, '0, '0});
			end else begin
				expected_rsp.push_back(predict_walk(item));
			end
		endfunction

		task report_mismatch(string what, int got, int want);
			mismatches++;
			$display("mismatch at result %0d: %s got %0d expected %0d",
			         results_seen, what, got, want);
		endtask

		task check_result(walk_rsp_t got);
			walk_rsp_t want;
			results_seen++;
			if (expected_rsp.size() == 0) begin
				report_mismatch("unexpected result, outcome", int'(got.outcome), -1);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.outcome !== want.outcome)
				report_mismatch("outcome", int'(got.outcome), int'(want.outcome));
			if (got.final_node !== want.final_node)
				report_mismatch("final_node", int'(got.final_node),
				                int'(want.final_node));
			if (got.hops_taken !== want.hops_taken)
				report_mismatch("hops_taken", int'(got.hops_taken),
				                int'(want.hops_taken));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [LIMIT_BITS-1:0] cfg_wdata;

	glw_req_if req_ch ();
	glw_rsp_if rsp_ch ();

	walk_scoreboard board = new();

	int burst_left;
	int ready_pct;
	bit long_hold_start;

	greedy_lightest_edge_walk_core #(
		.MAX_NODES   (NODE_COUNT),
		.WEIGHT_BITS (WEIGHT_IN_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// transfers on both channels, sampled at the edge that completes them
	always @(posedge clk) begin : monitor
		walk_rsp_t got_rsp;
		walk_req_t got_req;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_rsp.outcome    = rsp_ch.outcome;
				got_rsp.final_node = rsp_ch.final_node;
				got_rsp.hops_taken = rsp_ch.hops_taken;
				board.check_result(got_rsp);
			end
			if (req_ch.valid && req_ch.ready) begin
				got_req.operation     = req_ch.operation;
				got_req.edge_from     = req_ch.edge_from;
				got_req.edge_to       = req_ch.edge_to;
				got_req.edge_weight   = req_ch.edge_weight;
				got_req.start_node    = req_ch.start_node;
				got_req.dest_node     = req_ch.dest_node;
				got_req.initial_steps = req_ch.initial_steps;
				board.note_request(got_req);
			end
		end
	end

	// response side: random stalls, plus a long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_start) begin
				long_hold_start = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
			end
		end
	end

	initial begin : watchdog
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("TB_ERROR");
		$finish;
	end

	function automatic walk_req_t edge_item(int from_node, int to_node, int weight);
		walk_req_t item;
		item             = '0;
		item.operation   = OP_WRITE;
		item.edge_from   = NODE_BITS'(from_node);
		item.edge_to     = NODE_BITS'(to_node);
		item.edge_weight = WEIGHT_IN_BITS'(weight);
		return item;
	endfunction

	function automatic walk_req_t query_item(int start, int dest, int steps);
		walk_req_t item;
		item               = '0;
		item.operation     = OP_QUERY;
		item.start_node    = NODE_BITS'(start);
		item.dest_node     = NODE_BITS'(dest);
		item.initial_steps = STEP_BITS'(steps);
		return item;
	endfunction

	function automatic walk_req_t random_item(logic [LIMIT_BITS-1:0] limit);
		walk_req_t item;
		int        sel;
		// every field random, so unused fields carry noise
		item.edge_from     = NODE_BITS'($urandom_range(0, NODE_COUNT - 1));
		item.edge_to       = NODE_BITS'($urandom_range(0, NODE_COUNT - 1));
		item.edge_weight   = WEIGHT_IN_BITS'($urandom);
		item.start_node    = NODE_BITS'($urandom_range(0, NODE_COUNT - 1));
		item.dest_node     = NODE_BITS'($urandom_range(0, NODE_COUNT - 1));
		item.initial_steps = STEP_BITS'($urandom);
		if ($urandom_range(0, 99) < 45) begin
			item.operation = OP_WRITE;
			sel = $urandom_range(0, 99);
			// small weights give plenty of ties; zero removes an edge
			if (sel < 40)
				item.edge_weight = WEIGHT_IN_BITS'($urandom_range(1, 4));
			else if (sel < 55)
				item.edge_weight = '0;
			else if (sel < 70)
				item.edge_weight = WEIGHT_IN_BITS'($urandom_range(1, 300));
		end else begin
			item.operation = OP_QUERY;
			sel = $urandom_range(0, 99);
			if (sel < 75)
				item.initial_steps = STEP_BITS'($urandom_range(0, limit));
			else if (sel < 85)
				item.initial_steps = STEP_BITS'(limit) + STEP_BITS'(1);
		end
		return item;
	endfunction

	task automatic send_item(walk_req_t item);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(20, 60);
			else
				burst_left = $urandom_range(1, 8);
		end
		req_ch.valid         <= 1'b1;
		req_ch.operation     <= item.operation;
		req_ch.edge_from     <= item.edge_from;
		req_ch.edge_to       <= item.edge_to;
		req_ch.edge_weight   <= item.edge_weight;
		req_ch.start_node    <= item.start_node;
		req_ch.dest_node     <= item.dest_node;
		req_ch.initial_steps <= item.initial_steps;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_BITS-1:0] value);
		wait_drained();
		// extra idle clocks as margin after the last write result
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_limit(value);
	endtask

	initial begin : stimulus
		logic [LIMIT_BITS-1:0] limit_plan [PHASE_COUNT];
		int                    phase;
		int                    n;

		arst_n               = 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		req_ch.valid         <= 1'b0;
		req_ch.operation     <= OP_WRITE;
		req_ch.edge_from     <= '0;
		req_ch.edge_to       <= '0;
		req_ch.edge_weight   <= '0;
		req_ch.start_node    <= '0;
		req_ch.dest_node     <= '0;
		req_ch.initial_steps <= '0;
		burst_left           = 0;
		ready_pct            = 100;
		long_hold_start      = 1'b0;

		limit_plan[0] = 4'd8;
		limit_plan[1] = 4'd0;
		limit_plan[2] = 4'd15;
		limit_plan[3] = 4'd1;
		limit_plan[4] = LIMIT_BITS'($urandom_range(2, 14));
		limit_plan[5] = LIMIT_BITS'($urandom_range(0, 15));
		limit_plan[6] = LIMIT_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part at the reset limit of 7
		send_item(query_item(0, 1, 0));          // empty matrix: dead end
		send_item(query_item(0, 1, 255));        // over the step limit at once
		send_item(edge_item(0, 0, 16'hFFFF));    // self-loop, never taken
		send_item(query_item(0, 5, 0));
		send_item(edge_item(0, 3, 5));
		send_item(edge_item(0, 2, 5));           // tie, lower column wins
		send_item(edge_item(0, 6, 9));
		send_item(edge_item(2, 7, 1));           // column 7 outside the scan
		send_item(edge_item(2, 4, 16'hFFFF));
		send_item(edge_item(4, 0, 3));
		send_item(query_item(0, 4, 0));          // found after two hops
		send_item(query_item(0, 7, 0));          // cycles until the limit
		send_item(query_item(0, 3, 7));          // one hop, then limit
		send_item(query_item(0, 2, 8));
		send_item(edge_item(0, 2, 0));           // remove edge
		send_item(query_item(0, 3, 3));
		send_item(edge_item(3, 1, 16'h8000));
		send_item(edge_item(3, 5, 16'h7FFF));
		send_item(query_item(0, 1, 0));          // dead end at node 5
		send_item(query_item(5, 5, 0));
		send_item(query_item(7, 0, 0));
		send_item(query_item(4, 4, 0));          // start equals destination

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			write_limit(limit_plan[phase]);
			case (phase % 4)
				0: ready_pct = 100;
				1: ready_pct = 70;
				2: ready_pct = 35;
				default: ready_pct = 90;
			endcase
			if (phase == 0) begin
				send_item(query_item(2, 7, 0));  // column 7 now scanned
				send_item(query_item(2, 7, 9));
			end
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (phase == 2 && n == 20)
					long_hold_start = 1'b1;
				if (phase == 3 && n == 40)
					wait_drained();
				send_item(random_item(limit_plan[phase]));
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
